### sv/ffd_pkg.sv
// Shared types, sizes and frame-field helpers for the fixed-length frame deframer.
// No dependencies; every other file of the block imports this package.
package ffd_pkg;

    localparam int unsigned FRAME_BYTES  = 16;
    localparam int unsigned BUFFER_BYTES = 64;
    localparam int unsigned POS_W        = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned FRAME_IDX_W  = $clog2(FRAME_BYTES);

    localparam logic [7:0] HEAD_FIRST  = 8'hAA;
    localparam logic [7:0] HEAD_SECOND = 8'hBB;
    localparam logic [7:0] TAIL_MARK   = 8'hEE;

    localparam int unsigned WORD1_OFS = 2;
    localparam int unsigned WORD2_OFS = 6;
    localparam int unsigned WORD3_OFS = 10;
    localparam int unsigned FLAG_OFS  = 14;

    typedef logic [7:0] t_byte;
    typedef t_byte [FRAME_BYTES-1:0] t_frame;
    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic        found;
        logic [31:0] word_1;
        logic [31:0] word_2;
        logic [31:0] word_3;
        logic [7:0]  flag;
        logic [31:0] total;
        logic [6:0]  seen;
    } t_result;

    function automatic t_byte frame_byte(input t_frame f, input int unsigned k);
        if (k < FRAME_BYTES) begin
            return f[k[FRAME_IDX_W-1:0]];
        end
        return 8'h00;
    endfunction

    function automatic logic [31:0] frame_word(input t_frame f, input int unsigned k);
        return {frame_byte(f, k + 3), frame_byte(f, k + 2),
                frame_byte(f, k + 1), frame_byte(f, k)};
    endfunction

endpackage

### sv/ffd_cell.sv
// One byte cell of the sliding window: loads its upstream neighbor's byte on shift.
// Depends on ffd_pkg.
module ffd_cell
    import ffd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_byte i_byte,
    output t_byte o_byte
);

    t_byte r_byte;
    t_byte n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

### sv/ffd_window.sv
// Chain of byte cells holding the last FRAME_BYTES-1 bytes; presents the candidate frame
// with the current byte on top. Depends on ffd_pkg and ffd_cell.
module ffd_window
    import ffd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_byte  i_byte,
    output t_frame o_frame
);

    t_frame w_chain;

    assign w_chain[FRAME_BYTES-1] = i_byte;

    for (genvar k = 0; k < FRAME_BYTES - 1; k++) begin : g_cell
        ffd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_byte  (w_chain[k+1]),
            .o_byte  (w_chain[k])
        );
    end

    assign o_frame = w_chain;

endmodule

### sv/ffd_out_buf.sv
// Two-entry result buffer (output register plus skid) so input stays open while a
// result waits. Depends on ffd_pkg.
module ffd_out_buf
    import ffd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data,
    output logic    o_skid_valid
);

    logic    r_out_valid;
    logic    n_out_valid;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_out;
    t_result n_out;
    t_result r_skid;
    t_result n_skid;
    logic    w_pop;

    assign w_pop = r_out_valid & i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full       = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_data       = r_out;
    assign o_skid_valid = r_skid_valid;

endmodule

### sv/fixed_frame_deframer.sv
// Fixed-length frame deframer: one byte beat accepted per cycle while the output skid entry is free.
// A result is registered in the output buffer before it appears on the output.
// Throughput: 1 byte per cycle; input stalls only while both output entries hold results.
// Reset (synchronous, active low) clears window cells, position, seen flag, count, buffer valids.
// Depends on ffd_pkg, ffd_window, ffd_out_buf.
module fixed_frame_deframer
    import ffd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_buffer_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_found,
    output logic [31:0] o_payload_word_1,
    output logic [31:0] o_payload_word_2,
    output logic [31:0] o_payload_word_3,
    output logic [7:0]  o_flag_value,
    output logic [31:0] o_frames_total,
    output logic [6:0]  o_bytes_seen
);

    localparam t_pos POS_LIMIT = POS_W'(BUFFER_BYTES);
    localparam t_pos POS_FRAME = POS_W'(FRAME_BYTES);

    t_pos        r_pos;
    t_pos        n_pos;
    logic        r_seen;
    logic        n_seen;
    logic [31:0] r_count;
    logic [31:0] n_count;

    logic        w_accept;
    logic        w_in_range;
    t_pos        w_pos_inc;
    t_pos        w_pos_now;
    logic        w_hit;
    logic        w_push;
    logic        w_full;
    logic        w_skid_valid;
    t_frame      w_frame;
    t_result     w_res;
    t_result     w_out;

    assign w_accept   = i_in_valid & o_in_ready;
    assign w_in_range = r_pos < POS_LIMIT;
    assign w_pos_inc  = r_pos + t_pos'(1);
    assign w_pos_now  = w_in_range ? w_pos_inc : r_pos;

    ffd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_accept & w_in_range),
        .i_byte  (i_rx_byte),
        .o_frame (w_frame)
    );

    assign w_hit = w_in_range && !r_seen && (w_pos_inc >= POS_FRAME)
                   && (w_frame[0] == HEAD_FIRST) && (w_frame[1] == HEAD_SECOND)
                   && (w_frame[FRAME_BYTES-1] == TAIL_MARK);

    always_comb begin
        n_count = w_hit ? r_count + 32'd1 : r_count;
        w_res   = '0;
        w_res.total = n_count;
        w_res.seen  = 7'(w_pos_now);
        if (w_hit) begin
            w_res.found  = 1'b1;
            w_res.word_1 = frame_word(w_frame, WORD1_OFS);
            w_res.word_2 = frame_word(w_frame, WORD2_OFS);
            w_res.word_3 = frame_word(w_frame, WORD3_OFS);
            w_res.flag   = frame_byte(w_frame, FLAG_OFS);
        end
    end

    assign w_push = w_accept & (w_hit | (i_buffer_end & ~r_seen));

    always_comb begin
        n_pos  = r_pos;
        n_seen = r_seen;
        if (w_accept) begin
            if (i_buffer_end) begin
                n_pos  = '0;
                n_seen = 1'b0;
            end else begin
                n_pos  = w_pos_now;
                n_seen = r_seen | w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_seen  <= 1'b0;
            r_count <= '0;
        end else begin
            r_pos  <= n_pos;
            r_seen <= n_seen;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    ffd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_data       (w_res),
        .o_full       (w_full),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (w_out),
        .o_skid_valid (w_skid_valid)
    );

    assign o_in_ready       = ~w_full;
    assign o_frame_found    = w_out.found;
    assign o_payload_word_1 = w_out.word_1;
    assign o_payload_word_2 = w_out.word_2;
    assign o_payload_word_3 = w_out.word_3;
    assign o_flag_value     = w_out.flag;
    assign o_frames_total   = w_out.total;
    assign o_bytes_seen     = w_out.seen;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_skid_valid |-> o_out_valid)
        else $error("skid entry held without output entry");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("buffer position past limit");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_buffer_end) |=> (r_pos == '0 && !r_seen))
        else $error("buffer end did not clear position state");

    a_hit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_hit) |=> (r_count == $past(r_count) + 32'd1
                                 && r_seen == !$past(i_buffer_end)))
        else $error("frame hit not reflected in count or seen flag");
`endif

endmodule

### sim/fixed_frame_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for fixed_frame_deframer: byte beats in, frame reports out, random idling.
// Holds a frame tracker class that predicts and checks reports; depends on ffd_pkg and the RTL.

module fixed_frame_deframer_tb
    import ffd_pkg::*;
();

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned TARGET_BYTES = 1500;

    typedef t_byte t_frame_bytes [FRAME_BYTES];

    class frame_report_tracker;
        t_byte       window_q [FRAME_BYTES-1];
        int unsigned buf_pos;
        bit          frame_taken;
        logic [31:0] good_frames;
        t_result     due_reports [$];
        int unsigned miscompares;

        function new();
            foreach (window_q[k]) window_q[k] = '0;
            buf_pos     = 0;
            frame_taken = 1'b0;
            good_frames = '0;
            miscompares = 0;
        endfunction

        function t_byte frame_lane(t_frame_bytes f, int unsigned k);
            if (k >= FRAME_BYTES) return 8'h00;
            return f[k[FRAME_IDX_W-1:0]];
        endfunction

        function logic [31:0] frame_word(t_frame_bytes f, int unsigned k);
            logic [31:0] w;
            w = '0;
            for (int n = 0; n < 4; n++) w |= 32'(frame_lane(f, k + n)) << (8 * n);
            return w;
        endfunction

        function void note_rx_byte(t_byte b, logic last);
            t_frame_bytes frm;
            t_result      r;
            bit           hit;
            hit = 1'b0;
            if (buf_pos < BUFFER_BYTES) begin
                buf_pos++;
                for (int k = 0; k < FRAME_BYTES - 1; k++) frm[k] = window_q[k];
                frm[FRAME_BYTES-1] = b;
                for (int k = 0; k < FRAME_BYTES - 1; k++) window_q[k] = frm[k+1];
                if (!frame_taken && buf_pos >= FRAME_BYTES && frm[0] == HEAD_FIRST
                    && frm[1] == HEAD_SECOND && frm[FRAME_BYTES-1] == TAIL_MARK) begin
                    frame_taken = 1'b1;
                    good_frames++;
                    r.found  = 1'b1;
                    r.word_1 = frame_word(frm, WORD1_OFS);
                    r.word_2 = frame_word(frm, WORD2_OFS);
                    r.word_3 = frame_word(frm, WORD3_OFS);
                    r.flag   = frame_lane(frm, FLAG_OFS);
                    r.total  = good_frames;
                    r.seen   = 7'(buf_pos);
                    due_reports.push_back(r);
                    hit = 1'b1;
                end
            end
            if (last) begin
                if (!hit && !frame_taken) begin
                    r       = '0;
                    r.total = good_frames;
                    r.seen  = 7'(buf_pos);
                    due_reports.push_back(r);
                end
                buf_pos     = 0;
                frame_taken = 1'b0;
            end
        endfunction

        task report(string msg);
            $display("%0t ERROR %s", $time, msg);
            miscompares++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_report(t_result got);
            t_result want;
            if (due_reports.size() == 0) begin
                report($sformatf("unexpected report found=%b seen=%0d", got.found, got.seen));
                return;
            end
            want = due_reports.pop_front();
            compare_field("frame_found", 32'(got.found), 32'(want.found));
            compare_field("payload_word_1", got.word_1, want.word_1);
            compare_field("payload_word_2", got.word_2, want.word_2);
            compare_field("payload_word_3", got.word_3, want.word_3);
            compare_field("flag_value", 32'(got.flag), 32'(want.flag));
            compare_field("frames_total", got.total, want.total);
            compare_field("bytes_seen", 32'(got.seen), 32'(want.seen));
        endtask
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    t_byte       rx_byte    = '0;
    logic        buffer_end = 1'b0;
    logic        out_ready  = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        frame_found;
    logic [31:0] payload_word_1;
    logic [31:0] payload_word_2;
    logic [31:0] payload_word_3;
    logic [7:0]  flag_value;
    logic [31:0] frames_total;
    logic [6:0]  bytes_seen;

    frame_report_tracker tracker;
    int unsigned         bytes_sent  = 0;
    int unsigned         idle_cycles = 0;
    bit                  tx_calm     = 1'b0;
    bit                  rx_calm     = 1'b0;

    fixed_frame_deframer dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .i_buffer_end     (buffer_end),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_frame_found    (frame_found),
        .o_payload_word_1 (payload_word_1),
        .o_payload_word_2 (payload_word_2),
        .o_payload_word_3 (payload_word_3),
        .o_flag_value     (flag_value),
        .o_frames_total   (frames_total),
        .o_bytes_seen     (bytes_seen)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        t_result got;
        if (rst_n) begin
            if (in_valid && in_ready) tracker.note_rx_byte(rx_byte, buffer_end);
            if (out_valid && out_ready) begin
                got.found  = frame_found;
                got.word_1 = payload_word_1;
                got.word_2 = payload_word_2;
                got.word_3 = payload_word_3;
                got.flag   = flag_value;
                got.total  = frames_total;
                got.seen   = bytes_seen;
                tracker.check_report(got);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("fixed_frame_deframer: mismatch");
        $finish;
    end

    initial begin
        int unsigned stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_byte(input t_byte b, input logic last);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        rx_byte    <= b;
        buffer_end <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_buffer(input t_byte q[$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    function automatic t_byte noise_byte();
        case ($urandom_range(0, 7))
            0: return HEAD_FIRST;
            1: return HEAD_SECOND;
            2: return TAIL_MARK;
            default: return t_byte'($urandom);
        endcase
    endfunction

    function automatic void add_noise(ref t_byte q[$], input int unsigned n);
        repeat (n) q.push_back(noise_byte());
    endfunction

    function automatic void add_frame(ref t_byte q[$]);
        q.push_back(HEAD_FIRST);
        q.push_back(HEAD_SECOND);
        repeat (FRAME_BYTES - 3) q.push_back(noise_byte());
        q.push_back(TAIL_MARK);
    endfunction

    task automatic random_buffer();
        t_byte       q[$];
        t_byte       tail[$];
        int unsigned cut;
        int unsigned off;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                add_noise(q, ($urandom_range(0, 3) == 0) ? $urandom_range(30, 50)
                                                         : $urandom_range(0, 8));
                add_frame(q);
                if ($urandom_range(0, 2) == 0) add_frame(q);
                add_noise(q, $urandom_range(0, 6));
            end
            4: begin
                // damaged header or tail
                add_noise(q, $urandom_range(0, 8));
                add_frame(q);
                case ($urandom_range(0, 2))
                    0: off = 0;
                    1: off = 1;
                    default: off = FRAME_BYTES - 1;
                endcase
                cut = q.size() - FRAME_BYTES + off;
                q[cut] = q[cut] ^ t_byte'($urandom_range(1, 255));
                add_noise(q, $urandom_range(0, 4));
            end
            5: add_noise(q, $urandom_range(1, 24));
            6: begin
                // frame near or past the buffer limit
                add_noise(q, $urandom_range(40, 60));
                add_frame(q);
                add_noise(q, $urandom_range(0, 8));
            end
            7: begin
                add_noise(q, BUFFER_BYTES - FRAME_BYTES);
                add_frame(q);
                add_noise(q, $urandom_range(0, 3));
            end
            8: begin
                // frame split over two buffers
                add_noise(q, $urandom_range(0, 20));
                add_frame(tail);
                cut = $urandom_range(1, FRAME_BYTES - 1);
                for (int n = 0; n < cut; n++) q.push_back(tail.pop_front());
                send_buffer(q);
                q = tail;
                add_noise(q, $urandom_range(0, 4));
            end
            default: add_noise(q, $urandom_range(1, FRAME_BYTES - 1));
        endcase
        send_buffer(q);
    endtask

    initial begin
        t_byte       q[$];
        int unsigned buffers;
        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        q = '{HEAD_FIRST, HEAD_SECOND, TAIL_MARK};
        send_buffer(q);
        q.delete();
        q.push_back(HEAD_FIRST);
        q.push_back(HEAD_SECOND);
        repeat (FRAME_BYTES - 3) q.push_back(8'hFF);
        q.push_back(TAIL_MARK);
        send_buffer(q);
        q.delete();
        q.push_back(HEAD_FIRST);
        q.push_back(HEAD_SECOND);
        repeat (FRAME_BYTES - 3) q.push_back(8'h00);
        q.push_back(TAIL_MARK);
        q.push_back(8'h00);
        send_buffer(q);

        buffers = 0;
        while (bytes_sent < TARGET_BYTES) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            random_buffer();
            buffers++;
            if (buffers % 16 == 0) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (tracker.due_reports.size() != 0) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_reports.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (tracker.miscompares == 0) begin
            $display("fixed_frame_deframer: match");
        end else begin
            $display("fixed_frame_deframer: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
sv/ffd_pkg.sv
sv/ffd_cell.sv
sv/ffd_window.sv
sv/ffd_out_buf.sv
sv/fixed_frame_deframer.sv
sim/fixed_frame_deframer_tb.sv
